// ----- hdl/division_hash_linear_probe_table_top_macros.svh -----
// Assertion macros shared by the hash table modules.
`ifndef DIVISION_HASH_LINEAR_PROBE_TABLE_TOP_MACROS_SVH
`define DIVISION_HASH_LINEAR_PROBE_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DHLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");
`define DHLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle");
`else
`define DHLP_ASSERT_SAME(lbl, ante, cons)
`define DHLP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/dhlp_pkg.sv -----
// Shared widths and codes of the linear probing hash table.
package dhlp_pkg;

  localparam int KEY_W     = 21;
  localparam int PAY_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 7;
  localparam int MOD_W     = 8;
  localparam int COUNT_W   = 8;
  // Restoring-division steps retired per clock.
  localparam int DIV_STEP  = 3;

  localparam logic [MOD_W-1:0]   MODULUS_RESET = 8'd73;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

// ----- hdl/dhlp_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module dhlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/dhlp_mod.sv -----
// Multi-cycle restoring divider that yields key modulo table size.
`include "division_hash_linear_probe_table_top_macros.svh"

module dhlp_mod #(
  parameter int DW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dhlp_pkg::KEY_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [DW-1:0]              rem
);

  localparam int NCYC = (dhlp_pkg::KEY_W + dhlp_pkg::DIV_STEP - 1) / dhlp_pkg::DIV_STEP;
  localparam int PW   = NCYC * dhlp_pkg::DIV_STEP;
  localparam int CNTW = $clog2(NCYC + 1);

  logic [PW-1:0]   sh_r;
  logic [PW-1:0]   sh_nxt;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   rem_nxt;
  logic [DW-1:0]   d_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;

  // Each step shifts in one dividend bit and subtracts the divisor if it fits.
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [PW-1:0] s;
    r = rem_r;
    s = sh_r;
    for (int i = 0; i < dhlp_pkg::DIV_STEP; i++) begin
      t = {r, s[PW-1]};
      s = {s[PW-2:0], 1'b0};
      if (t >= {1'b0, d_r}) begin
        t = t - {1'b0, d_r};
      end
      r = t[DW-1:0];
    end
    rem_nxt = r;
    sh_nxt  = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(NCYC);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= PW'(dividend);
      rem_r <= '0;
      d_r   <= divisor;
    end else if (cnt_r != '0) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `DHLP_ASSERT_SAME(a_rem_below_divisor, done_r, rem_r < d_r)
  `DHLP_ASSERT_NEXT(a_start_loads_count, start, cnt_r == CNTW'(NCYC))
  `DHLP_ASSERT_NEXT(a_done_one_cycle, done_r, !done_r)

endmodule

// ----- hdl/division_hash_linear_probe_table_top.sv -----
// Open-addressing hash table with division hash and linear probing.
//
// After reset the block runs a clearing pass over the valid-bit memory;
// busy is high meanwhile. A search on an empty table answers straight from
// idle, in the cycle after it is accepted. Any other operation first runs the
// modulo divider (3 quotient bits per cycle over the 21-bit key, then the
// remainder is handed over), issues the home-slot read and then probes one
// slot after another, since the probe walk reads one memory entry per cycle.
// The result is on the out_ ports while out_strobe is high for exactly one
// cycle; it cannot be stalled, and busy falls in that same cycle. Write
// cfg_wr_data only while busy is low and no beat is pending.
`include "division_hash_linear_probe_table_top_macros.svh"

module division_hash_linear_probe_table_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [dhlp_pkg::KEY_W-1:0]    in_student_key,
  input  logic [dhlp_pkg::PAY_W-1:0]    in_payload,
  output logic                          out_strobe,
  output logic [dhlp_pkg::STATUS_W-1:0] out_status,
  output logic [dhlp_pkg::SLOT_W-1:0]   out_slot,
  output logic [dhlp_pkg::PAY_W-1:0]    out_found_payload,
  input  logic                          cfg_wr_en,
  input  logic [dhlp_pkg::MOD_W-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = (CW > dhlp_pkg::MOD_W) ? CW : dhlp_pkg::MOD_W;
  localparam int EW = dhlp_pkg::KEY_W + dhlp_pkg::PAY_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIV, S_PROBE} state_t;

  state_t                        state_r;
  logic [dhlp_pkg::MOD_W-1:0]    mod_r;
  logic                          func_r;
  logic [dhlp_pkg::KEY_W-1:0]    key_r;
  logic [dhlp_pkg::PAY_W-1:0]    pay_r;
  logic [CW-1:0]                 size_r;
  logic [dhlp_pkg::COUNT_W-1:0]  cnt_r;
  logic [AW-1:0]                 clr_addr_r;
  logic [AW-1:0]                 rd_pos_r;
  logic [CW-1:0]                 iss_r;
  logic                          chk_ok_r;
  logic [AW-1:0]                 chk_pos_r;
  logic [CW-1:0]                 chk_num_r;
  logic                          out_strobe_r;
  logic [dhlp_pkg::STATUS_W-1:0] out_status_r;
  logic [dhlp_pkg::SLOT_W-1:0]   out_slot_r;
  logic [dhlp_pkg::PAY_W-1:0]    out_pay_r;

  logic [MW-1:0]                 mod_ext;
  logic [CW-1:0]                 size_nxt;
  logic                          accept;
  logic                          empty_search;
  logic                          div_start;
  logic                          div_done;
  logic [CW-1:0]                 div_rem;
  logic [CW-1:0]                 pos_inc;
  logic [AW-1:0]                 pos_next;
  logic                          rd_en;
  logic                          hit;
  logic                          finish;
  logic                          ins_we;
  logic                          val_we;
  logic [AW-1:0]                 val_waddr;
  logic [EW-1:0]                 ent_q;
  logic                          val_q;
  logic [dhlp_pkg::KEY_W-1:0]    key_q;
  logic [dhlp_pkg::PAY_W-1:0]    pay_q;

  // Active size: zero counts as one, values beyond the memory saturate.
  assign mod_ext = MW'(mod_r);
  always_comb begin
    if (mod_r == '0) begin
      size_nxt = CW'(1);
    end else if (mod_ext > MW'(TABLE_DEPTH)) begin
      size_nxt = CW'(TABLE_DEPTH);
    end else begin
      size_nxt = CW'(mod_ext);
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign empty_search = (in_func == dhlp_pkg::FUNC_SEARCH) && (cnt_r == '0);
  assign div_start    = accept && !empty_search;

  dhlp_mod #(.DW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_student_key),
    .divisor  (size_nxt),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign pos_inc  = CW'(rd_pos_r) + CW'(1);
  assign pos_next = (pos_inc == size_r) ? '0 : AW'(pos_inc);

  assign key_q = ent_q[EW-1:dhlp_pkg::PAY_W];
  assign pay_q = ent_q[dhlp_pkg::PAY_W-1:0];

  // The entry checked this cycle was read in the previous one.
  assign hit    = (func_r == dhlp_pkg::FUNC_INSERT) ? !val_q : (val_q && (key_q == key_r));
  assign finish = (state_r == S_PROBE) && chk_ok_r && (hit || (chk_num_r == size_r));
  assign rd_en  = (state_r == S_PROBE) && !finish && (iss_r < size_r);
  assign ins_we = (state_r == S_PROBE) && chk_ok_r && hit && (func_r == dhlp_pkg::FUNC_INSERT);

  assign val_we    = (state_r == S_CLEAR) || ins_we;
  assign val_waddr = (state_r == S_CLEAR) ? clr_addr_r : chk_pos_r;

  dhlp_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (chk_pos_r),
    .wdata ({key_r, pay_r}),
    .re    (rd_en),
    .raddr (rd_pos_r),
    .rdata (ent_q)
  );

  dhlp_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (state_r != S_CLEAR),
    .re    (rd_en),
    .raddr (rd_pos_r),
    .rdata (val_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= dhlp_pkg::MODULUS_RESET;
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      cnt_r        <= '0;
      chk_ok_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      chk_ok_r     <= rd_en;
      chk_pos_r    <= rd_pos_r;
      if (rd_en) begin
        chk_num_r <= iss_r + CW'(1);
        rd_pos_r  <= pos_next;
        iss_r     <= iss_r + CW'(1);
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func;
            key_r  <= in_student_key;
            pay_r  <= in_payload;
            size_r <= size_nxt;
            if (empty_search) begin
              out_strobe_r <= 1'b1;
              out_status_r <= dhlp_pkg::ST_EMPTY;
              out_slot_r   <= '0;
              out_pay_r    <= '0;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rd_pos_r <= AW'(div_rem);
            iss_r    <= '0;
            state_r  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (finish) begin
            out_strobe_r <= 1'b1;
            state_r      <= S_IDLE;
            if (hit) begin
              out_slot_r <= dhlp_pkg::SLOT_W'(chk_pos_r);
              if (func_r == dhlp_pkg::FUNC_INSERT) begin
                out_status_r <= dhlp_pkg::ST_INSERTED;
                out_pay_r    <= '0;
                if (cnt_r != dhlp_pkg::COUNT_MAX) begin
                  cnt_r <= cnt_r + dhlp_pkg::COUNT_W'(1);
                end
              end else begin
                out_status_r <= dhlp_pkg::ST_FOUND;
                out_pay_r    <= pay_q;
              end
            end else begin
              out_slot_r   <= '0;
              out_pay_r    <= '0;
              out_status_r <= (func_r == dhlp_pkg::FUNC_INSERT) ?
                              dhlp_pkg::ST_FULL : dhlp_pkg::ST_NOT_FOUND;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_found_payload = out_pay_r;

  `DHLP_ASSERT_SAME(a_probe_in_range, chk_ok_r, CW'(chk_pos_r) < size_r)
  `DHLP_ASSERT_SAME(a_probe_count_bound, chk_ok_r, chk_num_r <= size_r)
  `DHLP_ASSERT_SAME(a_miss_zero_fields,
                    out_strobe_r && (out_status_r != dhlp_pkg::ST_INSERTED) &&
                    (out_status_r != dhlp_pkg::ST_FOUND),
                    (out_slot_r == '0) && (out_pay_r == '0))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the linear probing hash table.
module testbench;

  localparam int DEPTH = 128;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [dhlp_pkg::STATUS_W-1:0] status;
    logic [dhlp_pkg::SLOT_W-1:0]   slot;
    logic [dhlp_pkg::PAY_W-1:0]    found_payload;
  } hash_result_t;

  typedef struct {
    bit                           is_cfg;
    logic [dhlp_pkg::MOD_W-1:0]   cfg_val;
    logic                         func;
    logic [dhlp_pkg::KEY_W-1:0]   key;
    logic [dhlp_pkg::PAY_W-1:0]   payload;
    bit                           typed;
    hash_result_t                 want;
  } script_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_func;
  logic [dhlp_pkg::KEY_W-1:0]    in_student_key;
  logic [dhlp_pkg::PAY_W-1:0]    in_payload;
  logic                          out_strobe;
  logic [dhlp_pkg::STATUS_W-1:0] out_status;
  logic [dhlp_pkg::SLOT_W-1:0]   out_slot;
  logic [dhlp_pkg::PAY_W-1:0]    out_found_payload;
  logic                          cfg_wr_en;
  logic [dhlp_pkg::MOD_W-1:0]    cfg_wr_data;

  // Shadow copy of the table contents and its settings.
  logic [dhlp_pkg::KEY_W-1:0]    slot_key [DEPTH];
  logic [dhlp_pkg::PAY_W-1:0]    slot_pay [DEPTH];
  bit                            slot_used [DEPTH];
  logic [dhlp_pkg::COUNT_W-1:0]  entry_count;
  logic [dhlp_pkg::MOD_W-1:0]    modulus;

  hash_result_t                  pending_results [$];
  logic [dhlp_pkg::KEY_W-1:0]    stored_keys [$];
  script_row_t                   directed_script [$];
  logic [dhlp_pkg::MOD_W-1:0]    phase_moduli [10];
  int                            fail_count;

  division_hash_linear_probe_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_student_key   (in_student_key),
    .in_payload       (in_payload),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_found_payload(out_found_payload),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("division_hash_linear_probe_table_top test failed");
    $finish;
  end

  function automatic void report(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic int unsigned active_slots();
    if (modulus == '0) return 1;
    if (modulus > DEPTH) return DEPTH;
    return 32'(modulus);
  endfunction

  // Applies one operation to the shadow table and returns the answer it gives.
  function automatic hash_result_t probe_table(input logic f,
                                               input logic [dhlp_pkg::KEY_W-1:0] k,
                                               input logic [dhlp_pkg::PAY_W-1:0] p);
    hash_result_t r;
    int unsigned  m;
    int unsigned  pos;
    m = active_slots();
    pos = k % m;
    r = '0;
    if (f == dhlp_pkg::FUNC_INSERT) begin
      r.status = dhlp_pkg::ST_FULL;
      for (int n = 0; n < m; n++) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos] = k;
          slot_pay[pos] = p;
          if (entry_count < dhlp_pkg::COUNT_MAX) entry_count++;
          r.status = dhlp_pkg::ST_INSERTED;
          r.slot = dhlp_pkg::SLOT_W'(pos);
          return r;
        end
        pos = (pos + 1) % m;
      end
      return r;
    end
    if (entry_count == '0) begin
      r.status = dhlp_pkg::ST_EMPTY;
      return r;
    end
    r.status = dhlp_pkg::ST_NOT_FOUND;
    for (int n = 0; n < m; n++) begin
      if (slot_used[pos] && slot_key[pos] == k) begin
        r.status = dhlp_pkg::ST_FOUND;
        r.slot = dhlp_pkg::SLOT_W'(pos);
        r.found_payload = slot_pay[pos];
        return r;
      end
      pos = (pos + 1) % m;
    end
    return r;
  endfunction

  function automatic script_row_t op_row(input logic f, input logic [dhlp_pkg::KEY_W-1:0] k,
                                         input logic [dhlp_pkg::PAY_W-1:0] p, input bit typed,
                                         input logic [dhlp_pkg::STATUS_W-1:0] st,
                                         input logic [dhlp_pkg::SLOT_W-1:0] sl,
                                         input logic [dhlp_pkg::PAY_W-1:0] fp);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.func = f;
    row.key = k;
    row.payload = p;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = sl;
    row.want.found_payload = fp;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [dhlp_pkg::MOD_W-1:0] v);
    script_row_t row;
    row = op_row(dhlp_pkg::FUNC_SEARCH, '0, '0, 1'b0, dhlp_pkg::ST_INSERTED, '0, '0);
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  // Drives one beat and records its expected answer at the edge that accepts it.
  // Returns in the same time step as that edge, with start still high.
  task automatic issue_op(input logic f, input logic [dhlp_pkg::KEY_W-1:0] k,
                          input logic [dhlp_pkg::PAY_W-1:0] p, input int gap,
                          input bit typed, input hash_result_t want);
    hash_result_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_student_key <= k;
    in_payload <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = probe_table(f, k, p);
    pending_results.push_back(typed ? want : pred);
    if (f == dhlp_pkg::FUNC_INSERT) stored_keys.push_back(k);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [dhlp_pkg::MOD_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    modulus = v;
  endtask

  // Every result beat must match the oldest outstanding expectation.
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat at %0t: status %0d slot %0d payload %h",
                         $time, out_status, out_slot, out_found_payload));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_slot !== want.slot ||
            out_found_payload !== want.found_payload)
          report($sformatf({"mismatch at %0t: status exp %0d got %0d, slot exp %0d got %0d, ",
                            "payload exp %h got %h"}, $time, want.status, out_status,
                           want.slot, out_slot, want.found_payload, out_found_payload));
      end
    end
  end

  initial begin
    script_row_t                 row;
    logic                        f;
    logic [dhlp_pkg::KEY_W-1:0]  k;
    logic [dhlp_pkg::PAY_W-1:0]  p;
    int unsigned                 pick;
    int unsigned                 m;
    bit                          burst;
    int                          waited;

    rst_n = 1'b0;
    start = 1'b0;
    in_func = dhlp_pkg::FUNC_INSERT;
    in_student_key = '0;
    in_payload = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    fail_count = 0;
    entry_count = '0;
    modulus = dhlp_pkg::MODULUS_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_pay[i] = '0;
    end
    phase_moduli = '{8'd7, 8'd1, 8'd0, 8'd31, 8'd100, 8'd255, 8'd2, 8'd128, 8'd64, 8'd73};

    // Directed part, starting from the reset modulus of 73.
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd5, 16'h1111, 1,
                                     dhlp_pkg::ST_EMPTY, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd0, 16'h0000, 1,
                                     dhlp_pkg::ST_INSERTED, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'h1FFFFF, 16'hFFFF, 1,
                                     dhlp_pkg::ST_INSERTED, 7, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'h1FFFFF, 16'h0, 1,
                                     dhlp_pkg::ST_FOUND, 7, 16'hFFFF));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd0, 16'hFFFF, 1,
                                     dhlp_pkg::ST_FOUND, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd73, 16'h0, 1,
                                     dhlp_pkg::ST_NOT_FOUND, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd73, 16'h1234, 1,
                                     dhlp_pkg::ST_INSERTED, 1, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd146, 16'h2222, 1,
                                     dhlp_pkg::ST_INSERTED, 2, 0));
    // A second copy of key 73; search must still see the first one.
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd73, 16'h5555, 1,
                                     dhlp_pkg::ST_INSERTED, 3, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd73, 16'h0, 1,
                                     dhlp_pkg::ST_FOUND, 1, 16'h1234));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd72, 16'h0048, 1,
                                     dhlp_pkg::ST_INSERTED, 72, 0));
    // Home slot 72 is taken, so the probe wraps around to slot 4.
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd145, 16'h0145, 1,
                                     dhlp_pkg::ST_INSERTED, 4, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd145, 16'h0, 1,
                                     dhlp_pkg::ST_FOUND, 4, 16'h0145));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'h0AAAAA, 16'hAAAA, 0,
                                     dhlp_pkg::ST_INSERTED, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'h155555, 16'h5555, 0,
                                     dhlp_pkg::ST_INSERTED, 0, 0));
    // A modulus of zero acts as one: only slot 0 is live, and it is taken.
    directed_script.push_back(cfg_row(8'd0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd9, 16'h0001, 1,
                                     dhlp_pkg::ST_FULL, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'd0, 16'h0, 1,
                                     dhlp_pkg::ST_FOUND, 0, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'h1FFFFF, 16'h0, 1,
                                     dhlp_pkg::ST_NOT_FOUND, 0, 0));
    // Oversized modulus saturates to the full depth.
    directed_script.push_back(cfg_row(8'd200));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd127, 16'h7F7F, 1,
                                     dhlp_pkg::ST_INSERTED, 127, 0));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_SEARCH, 21'h1FFFFF, 16'h0, 0,
                                     dhlp_pkg::ST_INSERTED, 0, 0));
    directed_script.push_back(cfg_row(8'd2));
    directed_script.push_back(op_row(dhlp_pkg::FUNC_INSERT, 21'd3, 16'h0303, 1,
                                     dhlp_pkg::ST_FULL, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_script[i]) begin
      row = directed_script[i];
      if (row.is_cfg) write_modulus(row.cfg_val);
      else issue_op(row.func, row.key, row.payload, $urandom_range(0, 2), row.typed, row.want);
    end

    // Random part: each phase runs under its own modulus.
    for (int ph = 0; ph < 10; ph++) begin
      write_modulus(phase_moduli[ph]);
      burst = (ph % 3 == 1);
      m = active_slots();
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 39) == 0) drain();
        f = ($urandom_range(0, 99) < 45) ? dhlp_pkg::FUNC_INSERT : dhlp_pkg::FUNC_SEARCH;
        p = dhlp_pkg::PAY_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (stored_keys.size() != 0 &&
            ((f == dhlp_pkg::FUNC_SEARCH && pick < 5) ||
             (f == dhlp_pkg::FUNC_INSERT && pick < 2)))
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 7)
          k = dhlp_pkg::KEY_W'(m * $urandom_range(0, 20) + $urandom_range(0, 3));
        else if (pick == 7)
          k = dhlp_pkg::KEY_W'($urandom_range(0, 255));
        else
          k = dhlp_pkg::KEY_W'($urandom());
        issue_op(f, k, p, burst ? 0 : $urandom_range(0, 12), 1'b0, '0);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_results.size()));
    repeat (20) @(posedge clk);

    if (fail_count == 0)
      $display("division_hash_linear_probe_table_top test passed");
    else
      $display("division_hash_linear_probe_table_top test failed");
    $finish;
  end

endmodule
